[hdl/bia_pkg.sv]
// Shared types and constants for the block number allocator.
// Used by bia_ctrl, bia_stack and block_id_allocator; depends on nothing.
package bia_pkg;

  localparam int MaxBlocks = 256;
  localparam int IdW = 8;
  localparam int CountW = 9;

  // The usable pool is bounded by the stack depth and by the id space.
  localparam logic [CountW-1:0] CapLimit =
    CountW'((MaxBlocks < (1 << IdW)) ? MaxBlocks : (1 << IdW));

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Access to the free stack for one accepted request.
  typedef struct packed {
    logic           wr_en;
    logic [IdW-1:0] wr_addr;
    logic [IdW-1:0] wr_data;
    logic           rd_en;
    logic [IdW-1:0] rd_addr;
  } stack_req_t;

  // Decision for one request, captured in the result register.
  typedef struct packed {
    status_t        status;
    logic           from_stack;
    logic [IdW-1:0] fresh_id;
  } result_t;

endpackage

[hdl/bia_stack.sv]
// Free stack storage: one write port and one read port with registered data.
// Depends on bia_pkg for the request struct and sizes.
module bia_stack (
  input  logic                      clk,
  input  bia_pkg::stack_req_t       req,
  output logic [bia_pkg::IdW-1:0]   rd_data
);

  logic [bia_pkg::IdW-1:0] mem [bia_pkg::MaxBlocks];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // A push and a pop never come from the same request, so a read always sees
  // every push of earlier beats.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[hdl/bia_ctrl.sv]
// Request decoding, bump counter and stack pointer of the allocator.
// Depends on bia_pkg for mode and status codes and the shared structs.
module bia_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [1:0]                   mode,
  input  logic [bia_pkg::IdW-1:0]      free_id,
  input  logic [bia_pkg::CountW-1:0]   capacity,
  output bia_pkg::stack_req_t          stack_req,
  output bia_pkg::result_t             result
);

  logic [bia_pkg::CountW-1:0] next_fresh;
  logic [bia_pkg::CountW-1:0] next_fresh_next;
  logic [bia_pkg::CountW-1:0] stack_count;
  logic [bia_pkg::CountW-1:0] stack_count_next;
  logic [bia_pkg::CountW-1:0] cap_eff;
  logic [bia_pkg::CountW-1:0] top;

  // Capacities beyond the id space saturate.
  assign cap_eff = (capacity > bia_pkg::CapLimit) ? bia_pkg::CapLimit : capacity;
  assign top = stack_count - bia_pkg::CountW'(1);

  always_comb begin
    next_fresh_next    = next_fresh;
    stack_count_next   = stack_count;
    stack_req.wr_en    = 1'b0;
    stack_req.wr_addr  = stack_count[bia_pkg::IdW-1:0];
    stack_req.wr_data  = free_id;
    stack_req.rd_en    = 1'b0;
    stack_req.rd_addr  = top[bia_pkg::IdW-1:0];
    result.status      = bia_pkg::ST_OK;
    result.from_stack  = 1'b0;
    result.fresh_id    = '0;
    case (bia_pkg::mode_t'(mode))
      bia_pkg::MODE_ALLOC: begin
        if (stack_count != '0) begin
          stack_req.rd_en   = accept;
          result.from_stack = 1'b1;
          stack_count_next  = top;
        end else if (next_fresh >= cap_eff) begin
          result.status = bia_pkg::ST_EXHAUSTED;
        end else begin
          result.fresh_id = next_fresh[bia_pkg::IdW-1:0];
          next_fresh_next = next_fresh + bia_pkg::CountW'(1);
        end
      end
      bia_pkg::MODE_FREE: begin
        if ({1'b0, free_id} >= cap_eff) begin
          result.status = bia_pkg::ST_RANGE;
        end else if (stack_count >= cap_eff) begin
          result.status = bia_pkg::ST_FULL;
        end else begin
          stack_req.wr_en  = accept;
          stack_count_next = stack_count + bia_pkg::CountW'(1);
        end
      end
      bia_pkg::MODE_CLEAR: begin
        next_fresh_next  = '0;
        stack_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_fresh  <= '0;
      stack_count <= '0;
    end else if (accept) begin
      next_fresh  <= next_fresh_next;
      stack_count <= stack_count_next;
    end
  end

endmodule

[hdl/block_id_allocator.sv]
// Top level of the block number allocator: config register, result register.
// Depends on bia_pkg, bia_ctrl and bia_stack.

// Each request beat (allocate, free, clear or no-op) gives exactly one result
// beat in the cycle after it is accepted, and a new request can be accepted in
// every cycle in which no result is pending or the pending one is taken: the
// request is decided in one pass against the bump counter and the stack
// pointer, and the single result register frees up as the result is taken. A
// popped number comes from the 256 x 8 free stack memory through its registered
// read port. The stack needs no clearing pass after reset; a clear request only
// rewinds the pointers. Write pool_capacity only while no request is outstanding.
module block_id_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bia_pkg::CountW-1:0]  pool_capacity,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [1:0]                  mode,
  input  logic [bia_pkg::IdW-1:0]     free_id,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [bia_pkg::IdW-1:0]     granted_id,
  output logic [1:0]                  status
);

  logic [bia_pkg::CountW-1:0] capacity;
  logic                       accept;
  bia_pkg::stack_req_t        stack_req;
  bia_pkg::result_t           result_next;
  bia_pkg::result_t           result;
  logic [bia_pkg::IdW-1:0]    rd_data;

  assign cfg_ready = 1'b1;
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bia_pkg::CapLimit;
    end else if (cfg_valid) begin
      capacity <= pool_capacity;
    end
  end

  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (mode),
    .free_id   (free_id),
    .capacity  (capacity),
    .stack_req (stack_req),
    .result    (result_next)
  );

  bia_stack u_stack (
    .clk     (clk),
    .req     (stack_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // The stack read data only changes on a pop beat, so it holds with the result.
  assign granted_id = result.from_stack ? rd_data : result.fresh_id;
  assign status     = result.status;

endmodule
